### sv/keyed_lane_allocator_core_macros.svh
// Assertion macros shared by the lane allocator RTL.
// Included by kla_scan and keyed_lane_allocator_core; depends on nothing.
`ifndef KEYED_LANE_ALLOCATOR_CORE_MACROS_SVH
`define KEYED_LANE_ALLOCATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define KLA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kla assertion failed");
// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define KLA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kla assertion failed");
`else
`define KLA_ASSERT_IMPL(label, ante, cons)
`define KLA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### sv/kla_pkg.sv
// Shared codes and types of the keyed lane allocator.
// No dependencies; imported by kla_scan and keyed_lane_allocator_core.
package kla_pkg;

    localparam int STATUS_W   = 3;
    localparam int LANE_IDX_W = 6;
    localparam int KEY_IN_W   = 16;

    // Request opcodes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HELD      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FB_ORIENT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FB_FULL   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
    localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd6;

    // Only orientation +1 may take a lane
    localparam logic signed [1:0] ORIENT_PLUS = 2'sb01;

    // Scan control from the sequencer
    typedef struct packed {
        logic clear;
        logic sample;
    } t_scan_ctl;

    // Scan outcome flags back to the sequencer
    typedef struct packed {
        logic own_hit;
        logic free_hit;
    } t_scan_flags;

endpackage

### sv/kla_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the lane table.
module kla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/kla_scan.sv
// Lane scan datapath: tracks the first lane owned by the key and the first free lane.
// Depends on kla_pkg and the assertion macro header.
`include "keyed_lane_allocator_core_macros.svh"
module kla_scan
    import kla_pkg::*;
#(
    parameter int LANE_COUNT = 64,
    parameter int KEY_WIDTH  = 16,
    localparam int IW = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_scan_ctl            i_ctl,
    input  logic [IW-1:0]        i_idx,
    input  logic                 i_used,
    input  logic [KEY_WIDTH-1:0] i_owner,
    input  logic [KEY_WIDTH-1:0] i_key,
    output t_scan_flags          o_flags,
    output logic [IW-1:0]        o_own_idx,
    output logic [IW-1:0]        o_free_idx
);

    logic          r_own_hit;
    logic          r_free_hit;
    logic [IW-1:0] r_own_idx;
    logic [IW-1:0] r_free_idx;
    logic          w_match;

    assign w_match = i_used && (i_owner == i_key);

    // Hit flags: clear at scan start, latch the first hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_own_hit  <= 1'b0;
            r_free_hit <= 1'b0;
        end else if (i_ctl.sample) begin
            if (w_match) begin
                r_own_hit <= 1'b1;
            end
            if (!i_used) begin
                r_free_hit <= 1'b1;
            end
        end
    end

    // Lane numbers: hold the lowest hit
    always_ff @(posedge i_clk) begin
        if (i_ctl.sample && !r_own_hit && w_match) begin
            r_own_idx <= i_idx;
        end
        if (i_ctl.sample && !r_free_hit && !i_used) begin
            r_free_idx <= i_idx;
        end
    end

    assign o_flags.own_hit  = r_own_hit;
    assign o_flags.free_hit = r_free_hit;
    assign o_own_idx        = r_own_idx;
    assign o_free_idx       = r_free_idx;

    `KLA_ASSERT_NEXT(a_own_hit_needs_beat, !r_own_hit && !i_ctl.sample, !r_own_hit)
    `KLA_ASSERT_NEXT(a_free_idx_holds, r_free_hit && !i_ctl.clear, r_free_hit && $stable(r_free_idx))

endmodule

### sv/keyed_lane_allocator_core.sv
// Keyed lane allocator top level: sequencer, in-use valid bits and the lane table RAM.
// Depends on kla_pkg, kla_ram, kla_scan and the assertion macro header.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+---------------------------------------------
//  request   | start & !busy             | i_opcode i_key_present i_owner_key
//            |                           | i_hw_coupling i_orientation
//  result    | o_valid (one cycle)       | o_status o_lane_index o_fell_back
//
//  A request that needs the table runs from accept to the next accept through one read
//  per lane on the single RAM read port, a drain state for the last read beat and a
//  decide/write-back state. Invalid and wrong-orientation requests finish in the accept
//  cycle. The result beat shows the cycle after the request finishes. Reset clears the
//  in-use valid flops at once; no clearing pass. The receiver cannot stall; results are
//  never held.
`include "keyed_lane_allocator_core_macros.svh"
module keyed_lane_allocator_core
    import kla_pkg::*;
#(
    parameter int LANE_COUNT = 64,
    parameter int KEY_WIDTH  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_opcode,
    input  logic                  i_key_present,
    input  logic [KEY_IN_W-1:0]   i_owner_key,
    input  logic                  i_hw_coupling,
    input  logic signed [1:0]     i_orientation,
    output logic                  o_valid,
    output logic [STATUS_W-1:0]   o_status,
    output logic [LANE_IDX_W-1:0] o_lane_index,
    output logic                  o_fell_back
);

    localparam int IW = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
    localparam int DW = KEY_WIDTH + 1;
    localparam logic [IW-1:0] LAST_LANE = IW'(LANE_COUNT - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [IW-1:0]         r_addr, n_addr;
    logic                  r_rd_vld, n_rd_vld;
    logic [IW-1:0]         r_rd_idx, n_rd_idx;
    logic                  r_op, n_op;
    logic [KEY_WIDTH-1:0]  r_key, n_key;
    logic [LANE_COUNT-1:0] r_vld, n_vld;
    logic                  r_valid, n_valid;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [LANE_IDX_W-1:0] r_lane, n_lane;
    logic                  r_fb, n_fb;

    logic                  w_we;
    logic [IW-1:0]         w_waddr;
    logic [DW-1:0]         w_wdata;
    logic                  w_re;
    logic [DW-1:0]         w_rdata;
    logic                  w_used;
    t_scan_ctl             w_ctl;
    t_scan_flags           w_flags;
    logic [IW-1:0]         w_own_idx;
    logic [IW-1:0]         w_free_idx;

    // Lane table: in-use bit on top, owner key below
    kla_ram #(
        .WIDTH (DW),
        .DEPTH (LANE_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // Never-written entries read as free
    assign w_used = w_rdata[KEY_WIDTH] && r_vld[r_rd_idx];

    kla_scan #(
        .LANE_COUNT (LANE_COUNT),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_idx      (r_rd_idx),
        .i_used     (w_used),
        .i_owner    (w_rdata[KEY_WIDTH-1:0]),
        .i_key      (r_key),
        .o_flags    (w_flags),
        .o_own_idx  (w_own_idx),
        .o_free_idx (w_free_idx)
    );

    // Sequencer: accept, scan every lane, drain the last read beat, decide and write back
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_rd_vld  = 1'b0;
        n_rd_idx  = r_addr;
        n_op      = r_op;
        n_key     = r_key;
        n_vld     = r_vld;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_lane    = r_lane;
        n_fb      = r_fb;
        w_we      = 1'b0;
        w_waddr   = w_own_idx;
        w_wdata   = {1'b0, r_key};
        w_re      = 1'b0;
        w_ctl.clear  = 1'b0;
        w_ctl.sample = r_rd_vld;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = i_opcode;
                    n_key = KEY_WIDTH'(i_owner_key);
                    if (!i_key_present || (i_opcode == OP_ALLOC && !i_hw_coupling)) begin
                        n_valid  = 1'b1;
                        n_status = ST_INVALID;
                        n_lane   = '0;
                        n_fb     = 1'b0;
                    end else if (i_opcode == OP_ALLOC && i_orientation != ORIENT_PLUS) begin
                        n_valid  = 1'b1;
                        n_status = ST_FB_ORIENT;
                        n_lane   = '0;
                        n_fb     = 1'b1;
                    end else begin
                        n_state     = S_SCAN;
                        n_addr      = '0;
                        w_ctl.clear = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                w_re     = 1'b1;
                n_rd_vld = 1'b1;
                if (r_addr == LAST_LANE) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + IW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
                n_fb    = 1'b0;
                n_lane  = '0;
                if (r_op == OP_RELEASE) begin
                    if (w_flags.own_hit) begin
                        w_we     = 1'b1;
                        w_waddr  = w_own_idx;
                        w_wdata  = {1'b0, r_key};
                        n_status = ST_RELEASED;
                        n_lane   = LANE_IDX_W'(w_own_idx);
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end else if (w_flags.own_hit) begin
                    n_status = ST_HELD;
                    n_lane   = LANE_IDX_W'(w_own_idx);
                end else if (w_flags.free_hit) begin
                    w_we              = 1'b1;
                    w_waddr           = w_free_idx;
                    w_wdata           = {1'b1, r_key};
                    n_vld[w_free_idx] = 1'b1;
                    n_status          = ST_ALLOCATED;
                    n_lane            = LANE_IDX_W'(w_free_idx);
                end else begin
                    n_status = ST_FB_FULL;
                    n_fb     = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
            r_vld    <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
            r_vld    <= n_vld;
            r_valid  <= n_valid;
        end
    end

    // Payload and address registers
    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_rd_idx <= n_rd_idx;
        r_op     <= n_op;
        r_key    <= n_key;
        r_status <= n_status;
        r_lane   <= n_lane;
        r_fb     <= n_fb;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_lane_index = r_lane;
    assign o_fell_back  = r_fb;

    `KLA_ASSERT_NEXT(a_done_gives_beat, r_state == S_DONE, r_valid)
    `KLA_ASSERT_IMPL(a_write_only_in_done, w_we, r_state == S_DONE)
    `KLA_ASSERT_IMPL(a_fb_matches_status, r_valid, r_fb == ((r_status == ST_FB_ORIENT) || (r_status == ST_FB_FULL)))

endmodule
